// ----- rtl/core/sus_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique integer set package
// Shared widths, default capacity, operation codes and controller states.
// ----------------------------------------------------------------------------
package sus_pkg;

    localparam int VALUE_W      = 32;
    localparam int OP_W         = 2;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SRCH_OUT,
        ST_SH_RD,
        ST_SH_WR,
        ST_PUT,
        ST_RM_RD,
        ST_RM_WR,
        ST_LIST_RD,
        ST_LIST_WR
    } state_t;

endpackage

// ----- rtl/core/sorted_unique_integer_set.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique integer set
// Keeps distinct signed keys in ascending order in one synchronous memory.
// Each op but list scans for the lower bound. Insert and remove then shift one
// entry a cycle. List reads each entry, then waits for a free result slot to
// emit it; a search answer follows the scan.
// A new item is taken only in the idle state; the controller state sets it.
// Reset clears the occupancy and control; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_unique_integer_set #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [sus_pkg::OP_W-1:0]           op,
    input  logic signed [sus_pkg::VALUE_W-1:0] value,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               kind,
    output logic                               found,
    output logic signed [sus_pkg::VALUE_W-1:0] element,
    output logic                               last
);
    import sus_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;

    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic                      pend_reg, pend_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic [IW-1:0]             cnt_reg, cnt_next;
    logic [IW-1:0]             occ_reg, occ_next;
    logic                      found_reg, found_next;

    logic                      res_valid_reg, res_valid_next;
    logic                      res_kind_reg, res_kind_next;
    logic                      res_found_reg, res_found_next;
    logic signed [VALUE_W-1:0] res_elem_reg, res_elem_next;
    logic                      res_last_reg, res_last_next;

    logic                      mem_re, mem_we;
    logic [IW-1:0]             raddr, waddr;
    logic signed [VALUE_W-1:0] wdata;

    logic                      slot_free;
    logic                      stop_hit, scan_end, present, full;
    logic [IW-1:0]             pos_scan;
    logic [IW-1:0]             cnt_dec, cnt_inc, cnt_inc2, pos_inc;

    assign slot_free = !res_valid_reg || result_ready;
    assign stop_hit  = pend_reg && (rdata_reg >= val_reg);
    assign scan_end  = stop_hit || (idx_reg == occ_reg);
    assign pos_scan  = stop_hit ? (idx_reg - IW'(1)) : idx_reg;
    assign present   = stop_hit && (rdata_reg == val_reg);
    assign full      = (occ_reg == IW'(CAPACITY));
    assign cnt_dec   = cnt_reg - IW'(1);
    assign cnt_inc   = cnt_reg + IW'(1);
    assign cnt_inc2  = cnt_reg + IW'(2);
    assign pos_inc   = pos_scan + IW'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (op_t'(op) == OP_LIST)
                        state_next = (occ_reg == '0) ? ST_IDLE : ST_LIST_RD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    case (op_reg)
                        OP_SEARCH: state_next = ST_SRCH_OUT;
                        OP_INSERT:
                        begin
                            if (present || full)
                                state_next = ST_IDLE;
                            else if (pos_scan == occ_reg)
                                state_next = ST_PUT;
                            else
                                state_next = ST_SH_RD;
                        end
                        OP_REMOVE:
                        begin
                            if (!present || pos_inc == occ_reg)
                                state_next = ST_IDLE;
                            else
                                state_next = ST_RM_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SRCH_OUT: state_next = slot_free ? ST_IDLE : ST_SRCH_OUT;
            ST_SH_RD:    state_next = ST_SH_WR;
            ST_SH_WR:    state_next = (cnt_dec == pos_reg) ? ST_PUT : ST_SH_WR;
            ST_PUT:      state_next = ST_IDLE;
            ST_RM_RD:    state_next = ST_RM_WR;
            ST_RM_WR:    state_next = (cnt_inc2 < occ_reg) ? ST_RM_WR : ST_IDLE;
            ST_LIST_RD:  state_next = ST_LIST_WR;
            ST_LIST_WR:
            begin
                if (slot_free)
                    state_next = (cnt_inc == occ_reg) ? ST_IDLE : ST_LIST_RD;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        occ_next       = occ_reg;
        found_next     = found_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        raddr          = '0;
        waddr          = '0;
        wdata          = rdata_reg;
        res_kind_next  = res_kind_reg;
        res_found_next = res_found_reg;
        res_elem_next  = res_elem_reg;
        res_last_next  = res_last_reg;
        res_valid_next = res_valid_reg && !result_ready;
        item_ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    op_next   = op_t'(op);
                    val_next  = value;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    pend_next  = 1'b0;
                    pos_next   = pos_scan;
                    found_next = present;
                    cnt_next   = (op_reg == OP_REMOVE) ? pos_scan : occ_reg;
                    if (op_reg == OP_REMOVE && present && pos_inc == occ_reg)
                        occ_next = occ_reg - IW'(1);
                end
                else
                begin
                    mem_re    = 1'b1;
                    raddr     = idx_reg;
                    idx_next  = idx_reg + IW'(1);
                    pend_next = 1'b1;
                end
            end
            ST_SRCH_OUT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = 1'b0;
                    res_found_next = found_reg;
                    res_elem_next  = '0;
                    res_last_next  = 1'b1;
                end
            end
            ST_SH_RD:
            begin
                mem_re = 1'b1;
                raddr  = cnt_dec;
            end
            ST_SH_WR:
            begin
                mem_we   = 1'b1;
                waddr    = cnt_reg;
                wdata    = rdata_reg;
                cnt_next = cnt_dec;
                if (cnt_dec != pos_reg)
                begin
                    mem_re = 1'b1;
                    raddr  = cnt_reg - IW'(2);
                end
            end
            ST_PUT:
            begin
                mem_we   = 1'b1;
                waddr    = pos_reg;
                wdata    = val_reg;
                occ_next = occ_reg + IW'(1);
            end
            ST_RM_RD:
            begin
                mem_re = 1'b1;
                raddr  = cnt_inc;
            end
            ST_RM_WR:
            begin
                mem_we = 1'b1;
                waddr  = cnt_reg;
                wdata  = rdata_reg;
                if (cnt_inc2 < occ_reg)
                begin
                    mem_re   = 1'b1;
                    raddr    = cnt_inc2;
                    cnt_next = cnt_inc;
                end
                else
                begin
                    occ_next = occ_reg - IW'(1);
                end
            end
            ST_LIST_RD:
            begin
                mem_re = 1'b1;
                raddr  = cnt_reg;
            end
            ST_LIST_WR:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = 1'b1;
                    res_found_next = 1'b0;
                    res_elem_next  = rdata_reg;
                    res_last_next  = (cnt_inc == occ_reg);
                    cnt_next       = cnt_inc;
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg && !result_ready;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr[AW-1:0]] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        cnt_reg       <= cnt_next;
        found_reg     <= found_next;
        res_kind_reg  <= res_kind_next;
        res_found_reg <= res_found_next;
        res_elem_reg  <= res_elem_next;
        res_last_reg  <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign kind         = res_kind_reg;
    assign found        = res_found_reg;
    assign element      = res_elem_reg;
    assign last         = res_last_reg;

endmodule
